// ===== src/ttli_pkg.sv =====
`default_nettype none

package ttli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int WEIGHT_BITS = 16;

    localparam int FUNC_W        = 2;
    localparam int TIME_W        = 56;
    localparam int COORD_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 7;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    // query time and time differences carry one bit more than stored times
    localparam int T_W     = TIME_W + 1;
    localparam int REM_W   = T_W + 1;
    localparam int WCNT_W  = $clog2(WEIGHT_BITS + 1);
    localparam int PROD_W  = COORD_W + 1 + WEIGHT_BITS + 1;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_INTERP = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FIRST  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_LAST   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STORED = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_NOINT  = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } pos_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] t;
        pos_t                     pos;
    } entry_t;

    typedef struct packed {
        logic            start;
        logic [T_W-1:0]  num;
        logic [T_W-1:0]  den;
    } div_req_t;

    function automatic logic signed [T_W-1:0] ext_time(input logic signed [TIME_W-1:0] v);
        ext_time = T_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== src/ttli_if.sv =====
`default_nettype none

interface ttli_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [ttli_pkg::FUNC_W-1:0]              func;
    logic signed [ttli_pkg::TIME_W-1:0]       time_req;
    logic signed [ttli_pkg::COORD_W-1:0]      coord_x;
    logic signed [ttli_pkg::COORD_W-1:0]      coord_y;
    logic signed [ttli_pkg::COORD_W-1:0]      coord_z;

    modport source (output valid, func, time_req, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, func, time_req, coord_x, coord_y, coord_z, output ready);
endinterface

interface ttli_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ttli_pkg::COORD_W-1:0]      pos_x;
    logic signed [ttli_pkg::COORD_W-1:0]      pos_y;
    logic signed [ttli_pkg::COORD_W-1:0]      pos_z;
    logic [ttli_pkg::STATUS_W-1:0]            status;
    logic [ttli_pkg::ENTRY_COUNT_W-1:0]       entry_count;

    modport source (output valid, pos_x, pos_y, pos_z, status, entry_count, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, status, entry_count, output ready);
endinterface

interface ttli_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ttli_pkg::TIME_W-1:0]       data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/time_table_linear_interpolator.sv =====
// Clear and append: the result passes through the result register into the output register.
// Query: when empty likewise; when clamped to an end entry after reading the last and first entries;
// when interpolating after the one-entry-per-cycle table read port scan and the WEIGHT_BITS-step
// serial weight divider, then the blend. A new beat is taken only once the block is back in idle.
// Reset: fill count and time offset cleared; table contents are not cleared and only entries
// below the fill count are used.
`default_nettype none

module time_table_linear_interpolator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttli_cfg_if.sink    cfg,
    ttli_in_if.sink     req,
    ttli_out_if.source  rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LAST  = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_LERP  = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    localparam int ADDR_W  = ttli_pkg::ADDR_W;
    localparam int COUNT_W = ttli_pkg::COUNT_W;
    localparam int T_W     = ttli_pkg::T_W;

    logic [2:0]                           state_reg,  state_next;
    logic [COUNT_W-1:0]                   count_reg,  count_next;
    logic signed [ttli_pkg::TIME_W-1:0]   offset_reg;
    logic signed [T_W-1:0]                t_reg,      t_next;
    ttli_pkg::entry_t                     last_reg,   last_next;
    ttli_pkg::entry_t                     prev_reg,   prev_next;
    ttli_pkg::entry_t                     hi_reg,     hi_next;
    logic [ADDR_W-1:0]                    scan_idx_reg, scan_idx_next;
    ttli_pkg::pos_t                       res_pos_reg,  res_pos_next;
    logic [ttli_pkg::STATUS_W-1:0]        res_stat_reg, res_stat_next;

    logic                                 out_valid_reg, out_valid_next;
    ttli_pkg::pos_t                       out_pos_reg;
    logic [ttli_pkg::STATUS_W-1:0]        out_stat_reg;
    logic [ttli_pkg::ENTRY_COUNT_W-1:0]   out_count_reg;
    logic                                 out_load;

    logic                                 accept;
    logic                                 tbl_we;
    ttli_pkg::entry_t                     tbl_wdata;
    logic [ADDR_W-1:0]                    tbl_raddr;
    ttli_pkg::entry_t                     tbl_rdata;
    ttli_pkg::div_req_t                   div_req;
    logic                                 div_done;
    logic [ttli_pkg::WEIGHT_BITS-1:0]     div_w;
    logic                                 lerp_done;
    ttli_pkg::pos_t                       lerp_pos;
    logic signed [T_W-1:0]                rd_t, prev_t, last_t;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rd_t   = ttli_pkg::ext_time(tbl_rdata.t);
    assign prev_t = ttli_pkg::ext_time(prev_reg.t);
    assign last_t = ttli_pkg::ext_time(last_reg.t);

    assign tbl_wdata.t     = req.time_req;
    assign tbl_wdata.pos.x = req.coord_x;
    assign tbl_wdata.pos.y = req.coord_y;
    assign tbl_wdata.pos.z = req.coord_z;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  tbl_raddr = ADDR_W'(count_reg - 1'b1);
            S_LAST:  tbl_raddr = '0;
            S_FIRST: tbl_raddr = ADDR_W'(1);
            S_SCAN:  tbl_raddr = scan_idx_reg + 1'b1;
            default: tbl_raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        t_next        = t_reg;
        last_next     = last_reg;
        prev_next     = prev_reg;
        hi_next       = hi_reg;
        scan_idx_next = scan_idx_reg;
        res_pos_next  = res_pos_reg;
        res_stat_next = res_stat_reg;
        tbl_we        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = T_W'(t_reg - prev_t);
        div_req.den   = T_W'(rd_t - prev_t);
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_pos_next = '0;
                    state_next   = S_PUSH;
                    unique case (req.func)
                        ttli_pkg::FUNC_CLEAR:
                        begin
                            count_next    = '0;
                            res_stat_next = ttli_pkg::STAT_EMPTY;
                        end
                        ttli_pkg::FUNC_APPEND:
                        begin
                            if (count_reg < COUNT_W'(ttli_pkg::TABLE_DEPTH))
                            begin
                                tbl_we        = 1'b1;
                                count_next    = count_reg + 1'b1;
                                res_stat_next = ttli_pkg::STAT_STORED;
                            end
                            else
                            begin
                                res_stat_next = ttli_pkg::STAT_FULL;
                            end
                        end
                        default:
                        begin
                            t_next = ttli_pkg::ext_time(req.time_req)
                                     - ttli_pkg::ext_time(offset_reg);
                            if (count_reg == '0)
                            begin
                                res_stat_next = ttli_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LAST;
                            end
                        end
                    endcase
                end
            end
            S_LAST:
            begin
                last_next  = tbl_rdata;
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                if (t_reg <= rd_t)
                begin
                    res_pos_next  = tbl_rdata.pos;
                    res_stat_next = ttli_pkg::STAT_FIRST;
                    state_next    = S_PUSH;
                end
                else if (t_reg >= last_t)
                begin
                    res_pos_next  = last_reg.pos;
                    res_stat_next = ttli_pkg::STAT_LAST;
                    state_next    = S_PUSH;
                end
                else
                begin
                    prev_next     = tbl_rdata;
                    scan_idx_next = ADDR_W'(1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read data holds entry scan_idx, prev_reg holds the one before
                if (t_reg >= prev_t && t_reg < rd_t)
                begin
                    hi_next       = tbl_rdata;
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (scan_idx_reg == ADDR_W'(count_reg - 1'b1))
                begin
                    res_pos_next  = '0;
                    res_stat_next = ttli_pkg::STAT_NOINT;
                    state_next    = S_PUSH;
                end
                else
                begin
                    prev_next     = tbl_rdata;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                if (lerp_done)
                begin
                    res_pos_next  = lerp_pos;
                    res_stat_next = ttli_pkg::STAT_INTERP;
                    state_next    = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                offset_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        last_reg     <= last_next;
        prev_reg     <= prev_next;
        hi_reg       <= hi_next;
        scan_idx_reg <= scan_idx_next;
        res_pos_reg  <= res_pos_next;
        res_stat_reg <= res_stat_next;
        if (out_load)
        begin
            out_pos_reg   <= res_pos_reg;
            out_stat_reg  <= res_stat_reg;
            out_count_reg <= ttli_pkg::ENTRY_COUNT_W'(count_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pos_x       = out_pos_reg.x;
    assign rsp.pos_y       = out_pos_reg.y;
    assign rsp.pos_z       = out_pos_reg.z;
    assign rsp.status      = out_stat_reg;
    assign rsp.entry_count = out_count_reg;

    ttli_table u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ttli_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .done   (div_done),
        .weight (div_w)
    );

    ttli_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_done),
        .lo     (prev_reg.pos),
        .hi     (hi_reg.pos),
        .weight (div_w),
        .done   (lerp_done),
        .result (lerp_pos)
    );

endmodule

`default_nettype wire

// ===== src/ttli_table.sv =====
`default_nettype none

module ttli_table (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ttli_pkg::ADDR_W-1:0] waddr,
    input  wire ttli_pkg::entry_t            wdata,
    input  wire logic [ttli_pkg::ADDR_W-1:0] raddr,
    output ttli_pkg::entry_t                 rdata
);

    ttli_pkg::entry_t mem [ttli_pkg::TABLE_DEPTH];
    ttli_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/ttli_div.sv =====
`default_nettype none

// Restoring fraction divider: w = floor(num * 2^WEIGHT_BITS / den), num < den.
module ttli_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ttli_pkg::div_req_t               req,
    output logic                                  done,
    output logic [ttli_pkg::WEIGHT_BITS-1:0]      weight
);

    logic                                busy_reg,  busy_next;
    logic                                done_reg,  done_next;
    logic [ttli_pkg::WCNT_W-1:0]         cnt_reg,   cnt_next;
    logic [ttli_pkg::REM_W-1:0]          rem_reg,   rem_next;
    logic [ttli_pkg::REM_W-1:0]          den_reg,   den_next;
    logic [ttli_pkg::WEIGHT_BITS-1:0]    w_reg,     w_next;
    logic [ttli_pkg::REM_W-1:0]          rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        w_next    = w_reg;
        rem_sh    = {rem_reg[ttli_pkg::REM_W-2:0], 1'b0};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ttli_pkg::WCNT_W'(ttli_pkg::WEIGHT_BITS);
            rem_next  = ttli_pkg::REM_W'(req.num);
            den_next  = ttli_pkg::REM_W'(req.den);
            w_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= den_reg)
            begin
                rem_next = rem_sh - den_reg;
                w_next   = {w_reg[ttli_pkg::WEIGHT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                w_next   = {w_reg[ttli_pkg::WEIGHT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ttli_pkg::WCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        w_reg   <= w_next;
    end

    assign done   = done_reg;
    assign weight = w_reg;

endmodule

`default_nettype wire

// ===== src/ttli_lerp.sv =====
`default_nettype none

// Two-stage blend: registered products, then a + floor(prod / 2^WEIGHT_BITS).
module ttli_lerp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire ttli_pkg::pos_t                lo,
    input  wire ttli_pkg::pos_t                hi,
    input  wire logic [ttli_pkg::WEIGHT_BITS-1:0] weight,
    output logic                               done,
    output ttli_pkg::pos_t                     result
);

    typedef logic signed [ttli_pkg::PROD_W-1:0] prod_t;

    logic           p_valid_reg;
    logic           done_reg;
    prod_t          px_reg, py_reg, pz_reg;
    ttli_pkg::pos_t lo_reg;
    ttli_pkg::pos_t result_reg;

    function automatic prod_t scaled_diff(input logic signed [ttli_pkg::COORD_W-1:0] a,
                                          input logic signed [ttli_pkg::COORD_W-1:0] b,
                                          input logic [ttli_pkg::WEIGHT_BITS-1:0] w);
        logic signed [ttli_pkg::COORD_W:0]       diff;
        logic signed [ttli_pkg::WEIGHT_BITS:0]   ws;
        diff = $signed({b[ttli_pkg::COORD_W-1], b}) - $signed({a[ttli_pkg::COORD_W-1], a});
        ws   = $signed({1'b0, w});
        scaled_diff = prod_t'(diff) * prod_t'(ws);
    endfunction

    function automatic logic signed [ttli_pkg::COORD_W-1:0] add_step(
        input logic signed [ttli_pkg::COORD_W-1:0] a,
        input prod_t p);
        prod_t step;
        step = p >>> ttli_pkg::WEIGHT_BITS;
        add_step = a + step[ttli_pkg::COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= start;
            done_reg    <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg <= scaled_diff(lo.x, hi.x, weight);
            py_reg <= scaled_diff(lo.y, hi.y, weight);
            pz_reg <= scaled_diff(lo.z, hi.z, weight);
            lo_reg <= lo;
        end
        if (p_valid_reg)
        begin
            result_reg.x <= add_step(lo_reg.x, px_reg);
            result_reg.y <= add_step(lo_reg.y, py_reg);
            result_reg.z <= add_step(lo_reg.z, pz_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/ttli_checker.sv =====
`default_nettype none

module ttli_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   rsp_valid,
    input wire logic                                   rsp_ready,
    input wire logic signed [ttli_pkg::COORD_W-1:0]    rsp_pos_x,
    input wire logic signed [ttli_pkg::COORD_W-1:0]    rsp_pos_y,
    input wire logic signed [ttli_pkg::COORD_W-1:0]    rsp_pos_z,
    input wire logic [ttli_pkg::STATUS_W-1:0]          rsp_status,
    input wire logic [ttli_pkg::ENTRY_COUNT_W-1:0]     rsp_entry_count
);

    // a waiting result beat holds still
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_pos_z)
            && $stable(rsp_entry_count))
        else $error("result beat changed while stalled");

    // failed or non-query answers carry a zero position
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ttli_pkg::STAT_EMPTY
            || rsp_status == ttli_pkg::STAT_STORED
            || rsp_status == ttli_pkg::STAT_FULL
            || rsp_status == ttli_pkg::STAT_NOINT)
        |-> rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0)
        else $error("nonzero position on a non-position answer");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ttli_pkg::STAT_EMPTY |-> rsp_entry_count == '0)
        else $error("empty answer with entries in the table");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ttli_pkg::STAT_FULL
        |-> rsp_entry_count == ttli_pkg::ENTRY_COUNT_W'(ttli_pkg::TABLE_DEPTH))
        else $error("dropped append with table not full");

endmodule

bind time_table_linear_interpolator ttli_checker u_ttli_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_pos_x       (rsp.pos_x),
    .rsp_pos_y       (rsp.pos_y),
    .rsp_pos_z       (rsp.pos_z),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ttli_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_QUERY     = 2'd2;
    // selector three decodes as a query
    localparam logic [FUNC_W-1:0] FUNC_QUERY_ALT = 2'd3;

    localparam longint T_MAX = (64'sd1 <<< 55) - 1;
    localparam longint T_MIN = -T_MAX - 1;
    localparam longint C_MAX = 64'sd2147483647;
    localparam longint C_MIN = -C_MAX - 1;

    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 900000;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [TIME_W-1:0]  t;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } tt_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic [STATUS_W-1:0]        status;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    ttli_cfg_if cfg_bus ();
    ttli_in_if  req_bus ();
    ttli_out_if rsp_bus ();

    time_table_linear_interpolator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #2 clk = ~clk;

    // shadow of the block's table and offset register
    logic signed [TIME_W-1:0]  tbl_time [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tbl_x    [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tbl_y    [TABLE_DEPTH];
    logic signed [COORD_W-1:0] tbl_z    [TABLE_DEPTH];
    int                        tbl_fill = 0;
    logic signed [TIME_W-1:0]  cur_offset = '0;

    answer_t  due_answers [$];
    tt_item_t dir_items   [$];
    bit       dir_typed   [$];
    answer_t  dir_ans     [$];

    int items_sent = 0;
    int mismatches = 0;
    bit send_calm  = 1'b0;
    bit recv_calm  = 1'b0;

    function automatic int pause_len(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic longint rand_time();
        logic [TIME_W-1:0] v;
        v = TIME_W'({$urandom, $urandom});
        return longint'($signed(v));
    endfunction

    function automatic longint rand_span(input longint lo, input longint hi);
        longint unsigned span;
        longint unsigned r;
        span = hi - lo;
        r = {$urandom, $urandom};
        if (span != '1)
            r = r % (span + 1);
        return lo + longint'(r);
    endfunction

    // floor(num * 2^WEIGHT_BITS / den), num < den
    function automatic logic [WEIGHT_BITS-1:0] frac_of(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned r;
        logic [WEIGHT_BITS-1:0] w;
        r = num;
        w = '0;
        for (int k = 0; k < WEIGHT_BITS; k++)
        begin
            r = r << 1;
            w = {w[WEIGHT_BITS-2:0], 1'b0};
            if (r >= den)
            begin
                r = r - den;
                w[0] = 1'b1;
            end
        end
        return w;
    endfunction

    // a + floor((b - a) * w / 2^WEIGHT_BITS); arithmetic shift floors toward -inf
    function automatic logic signed [COORD_W-1:0] blend(input logic signed [COORD_W-1:0] a,
                                                         input logic signed [COORD_W-1:0] b,
                                                         input logic [WEIGHT_BITS-1:0] w);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'({1'b0, w});
        return COORD_W'(longint'(a) + (prod >>> WEIGHT_BITS));
    endfunction

    function automatic answer_t lookup_position(input tt_item_t it);
        answer_t a;
        longint  q;
        longint  lo;
        longint  hi;
        logic [WEIGHT_BITS-1:0] w;
        bit hit;
        a = '0;
        if (it.func == FUNC_CLEAR)
        begin
            tbl_fill = 0;
            a.status = STAT_EMPTY;
        end
        else if (it.func == FUNC_APPEND)
        begin
            if (tbl_fill < TABLE_DEPTH)
            begin
                tbl_time[tbl_fill] = it.t;
                tbl_x[tbl_fill]    = it.x;
                tbl_y[tbl_fill]    = it.y;
                tbl_z[tbl_fill]    = it.z;
                tbl_fill++;
                a.status = STAT_STORED;
            end
            else
                a.status = STAT_FULL;
        end
        else
        begin
            q = longint'($signed(it.t)) - longint'(cur_offset);
            if (tbl_fill == 0)
                a.status = STAT_EMPTY;
            else if (q <= longint'(tbl_time[0]))
            begin
                a.pos_x = tbl_x[0];
                a.pos_y = tbl_y[0];
                a.pos_z = tbl_z[0];
                a.status = STAT_FIRST;
            end
            else if (q >= longint'(tbl_time[tbl_fill-1]))
            begin
                a.pos_x = tbl_x[tbl_fill-1];
                a.pos_y = tbl_y[tbl_fill-1];
                a.pos_z = tbl_z[tbl_fill-1];
                a.status = STAT_LAST;
            end
            else
            begin
                hit = 1'b0;
                a.status = STAT_NOINT;
                for (int i = 0; i + 1 < tbl_fill && !hit; i++)
                begin
                    lo = longint'(tbl_time[i]);
                    hi = longint'(tbl_time[i+1]);
                    if (q >= lo && q < hi)
                    begin
                        w = frac_of(q - lo, hi - lo);
                        a.pos_x = blend(tbl_x[i], tbl_x[i+1], w);
                        a.pos_y = blend(tbl_y[i], tbl_y[i+1], w);
                        a.pos_z = blend(tbl_z[i], tbl_z[i+1], w);
                        a.status = STAT_INTERP;
                        hit = 1'b1;
                    end
                end
            end
        end
        a.entry_count = ENTRY_COUNT_W'(tbl_fill);
        return a;
    endfunction

    function automatic answer_t mk_ans(input longint x, input longint y, input longint z,
                                       input logic [STATUS_W-1:0] st, input int n);
        answer_t a;
        a.pos_x = COORD_W'(x);
        a.pos_y = COORD_W'(y);
        a.pos_z = COORD_W'(z);
        a.status = st;
        a.entry_count = ENTRY_COUNT_W'(n);
        return a;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] f, input longint t, input longint x,
                           input longint y, input longint z, input bit typed,
                           input answer_t ans);
        tt_item_t r;
        r.func = f;
        r.t = TIME_W'(t);
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.z = COORD_W'(z);
        dir_items = {dir_items, r};
        dir_typed = {dir_typed, typed};
        dir_ans   = {dir_ans, ans};
    endtask

    task automatic send_item(input tt_item_t it, input bit typed, input answer_t typed_ans);
        answer_t a;
        int gap;
        gap = pause_len(send_calm);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.func     <= it.func;
        req_bus.time_req <= it.t;
        req_bus.coord_x  <= it.x;
        req_bus.coord_y  <= it.y;
        req_bus.coord_z  <= it.z;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        a = lookup_position(it);
        due_answers = {due_answers, (typed ? typed_ans : a)};
        items_sent++;
    endtask

    task automatic settle();
        req_bus.valid <= 1'b0;
        while (due_answers.size() != 0) @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [TIME_W-1:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        cur_offset = v;
    endtask

    function automatic tt_item_t rand_item(input logic [FUNC_W-1:0] f, input longint t);
        tt_item_t it;
        it.func = f;
        it.t = TIME_W'(t);
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        return it;
    endfunction

    // response side
    initial
    begin : rsp_side
        answer_t got;
        answer_t want;
        int stall;
        int beat_no;
        beat_no = 0;
        forever
        begin
            stall = pause_len(recv_calm);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (rsp_bus.valid !== 1'b1);
            got.pos_x       = rsp_bus.pos_x;
            got.pos_y       = rsp_bus.pos_y;
            got.pos_z       = rsp_bus.pos_z;
            got.status      = rsp_bus.status;
            got.entry_count = rsp_bus.entry_count;
            if (due_answers.size() == 0)
            begin
                if (mismatches < 10)
                    $display("beat %0d: result with nothing outstanding, status=%0d count=%0d",
                             beat_no, got.status, got.entry_count);
                mismatches++;
            end
            else
            begin
                want = due_answers.pop_front();
                if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                    got.pos_z !== want.pos_z || got.status !== want.status ||
                    got.entry_count !== want.entry_count)
                begin
                    if (mismatches < 10)
                    begin
                        $write("beat %0d: exp x=%0d y=%0d z=%0d st=%0d n=%0d, ",
                               beat_no, want.pos_x, want.pos_y, want.pos_z, want.status,
                               want.entry_count);
                        $display("got x=%0d y=%0d z=%0d st=%0d n=%0d",
                                 got.pos_x, got.pos_y, got.pos_z, got.status,
                                 got.entry_count);
                    end
                    mismatches++;
                end
            end
            beat_no++;
        end
    end

    initial
    begin : watchdog
        int n;
        n = 0;
        while (n < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        tt_item_t it;
        int n;
        int m;
        int idx;
        longint t;
        longint ofs;
        longint start;
        longint maxgap;
        longint ptimes [$];

        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.func     <= FUNC_CLEAR;
        req_bus.time_req <= '0;
        req_bus.coord_x  <= '0;
        req_bus.coord_y  <= '0;
        req_bus.coord_z  <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.data     <= '0;

        // directed rows, offset still at its reset value
        add_row(FUNC_QUERY, 0, 0, 0, 0, 1, mk_ans(0, 0, 0, STAT_EMPTY, 0));
        add_row(FUNC_APPEND, T_MIN, C_MAX, C_MIN, 0, 1, mk_ans(0, 0, 0, STAT_STORED, 1));
        add_row(FUNC_QUERY, T_MIN, 0, 0, 0, 1, mk_ans(C_MAX, C_MIN, 0, STAT_FIRST, 1));
        add_row(FUNC_QUERY, T_MAX, 0, 0, 0, 1, mk_ans(C_MAX, C_MIN, 0, STAT_LAST, 1));
        add_row(FUNC_CLEAR, 0, 0, 0, 0, 1, mk_ans(0, 0, 0, STAT_EMPTY, 0));
        add_row(FUNC_QUERY, 5, 0, 0, 0, 1, mk_ans(0, 0, 0, STAT_EMPTY, 0));
        add_row(FUNC_APPEND, T_MIN, C_MIN, C_MAX, -1, 1, mk_ans(0, 0, 0, STAT_STORED, 1));
        add_row(FUNC_APPEND, T_MAX, C_MAX, C_MIN, 1, 1, mk_ans(0, 0, 0, STAT_STORED, 2));
        // full-span interval: widest time difference
        add_row(FUNC_QUERY, 0, 0, 0, 0, 0, '0);
        add_row(FUNC_QUERY, T_MAX - 1, 0, 0, 0, 0, '0);
        add_row(FUNC_QUERY, T_MIN + 1, 0, 0, 0, 0, '0);
        add_row(FUNC_QUERY_ALT, -12345, 0, 0, 0, 0, '0);
        add_row(FUNC_QUERY, T_MAX, 0, 0, 0, 1, mk_ans(C_MAX, C_MIN, 1, STAT_LAST, 2));
        add_row(FUNC_CLEAR, 0, 0, 0, 0, 1, mk_ans(0, 0, 0, STAT_EMPTY, 0));
        add_row(FUNC_APPEND, 100, 1000, -1000, 7, 1, mk_ans(0, 0, 0, STAT_STORED, 1));
        add_row(FUNC_QUERY, 100, 0, 0, 0, 1, mk_ans(1000, -1000, 7, STAT_FIRST, 1));
        add_row(FUNC_QUERY_ALT, 101, 0, 0, 0, 1, mk_ans(1000, -1000, 7, STAT_LAST, 1));
        add_row(FUNC_APPEND, 300, -1000, 1000, -7, 1, mk_ans(0, 0, 0, STAT_STORED, 2));
        // out of order entry
        add_row(FUNC_APPEND, 200, 5, 5, 5, 1, mk_ans(0, 0, 0, STAT_STORED, 3));
        add_row(FUNC_QUERY, 150, 0, 0, 0, 0, '0);
        add_row(FUNC_QUERY, 299, 0, 0, 0, 0, '0);
        add_row(FUNC_QUERY, 250, 0, 0, 0, 0, '0);
        // duplicate time
        add_row(FUNC_APPEND, 200, -5, -5, -5, 1, mk_ans(0, 0, 0, STAT_STORED, 4));
        add_row(FUNC_QUERY, 200, 0, 0, 0, 0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < dir_items.size(); r++)
            send_item(dir_items[r], dir_typed[r], dir_ans[r]);

        while (items_sent < dir_items.size() + RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 6))
                0:       ofs = 0;
                1:       ofs = T_MAX;
                2:       ofs = T_MIN;
                3:       ofs = rand_time();
                default: ofs = longint'($urandom_range(0, 2000)) - 1000;
            endcase
            write_offset(TIME_W'(ofs));

            if ($urandom_range(0, 4) == 0)
            begin
                // noise: any selector, any time
                n = $urandom_range(8, 30);
                repeat (n)
                begin
                    it = rand_item(FUNC_W'($urandom_range(0, 3)), rand_time());
                    send_item(it, 1'b0, '0);
                end
            end
            else
            begin
                // sorted table, then queries around it; sometimes no clear first
                if ($urandom_range(0, 5) != 0)
                    send_item(rand_item(FUNC_CLEAR, rand_time()), 1'b0, '0);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
                case ($urandom_range(0, 2))
                    0:       maxgap = 15;
                    1:       maxgap = 64'sd1 <<< 20;
                    default: maxgap = 64'sd1 <<< 48;
                endcase
                start = rand_time();
                if (start > T_MAX - n * maxgap)
                    start = T_MAX - n * maxgap;
                ptimes.delete();
                t = start;
                for (int k = 0; k < n; k++)
                begin
                    ptimes = {ptimes, t};
                    send_item(rand_item(FUNC_APPEND, t), 1'b0, '0);
                    t = t + rand_span(0, maxgap);
                end
                m = $urandom_range(4, 24);
                repeat (m)
                begin
                    idx = $urandom_range(0, n - 1);
                    it = rand_item(($urandom_range(0, 5) == 0) ? FUNC_QUERY_ALT : FUNC_QUERY, 0);
                    case ($urandom_range(0, 7))
                        0: t = ptimes[idx] + ofs;
                        1: t = ptimes[idx] + longint'($urandom_range(0, 2)) - 1 + ofs;
                        2, 3: t = rand_span(ptimes[0] - 2, ptimes[n-1] + 2) + ofs;
                        4: t = ((idx + 1 < n) ? rand_span(ptimes[idx], ptimes[idx+1])
                                              : ptimes[idx]) + ofs;
                        5:
                        begin
                            // stray append breaks the ordering
                            it.func = FUNC_APPEND;
                            t = rand_span(ptimes[0] - 2, ptimes[n-1] + 2);
                        end
                        default: t = rand_time();
                    endcase
                    it.t = TIME_W'(t);
                    send_item(it, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/ttli_pkg.sv
src/ttli_if.sv
src/ttli_table.sv
src/ttli_div.sv
src/ttli_lerp.sv
src/time_table_linear_interpolator.sv
src/ttli_checker.sv
dv/tb.sv
